/* src/cvr_pkg.sv */
// ---------------------------------------------------------------------------
// cvr_pkg: shared types and constants of the camera view rotate unit
// Fixed widths, register indexes, reset values and the item structs that
// pass between the rotation stages and the sine/cosine sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

package cvr_pkg;

  // Coordinate and angle widths.
  localparam int COORD_W   = 24;
  localparam int OUT_W     = COORD_W + 2;
  localparam int ANG_W     = 16;
  localparam int TRIG_FRAC = 16;
  localparam int TRIG_W    = TRIG_FRAC + 2;

  // Rotation datapath widths.
  localparam int ROT_W  = OUT_W;
  localparam int PROD_W = ROT_W + TRIG_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int SIDE_W = ROT_W + 1;

  // Stream packing.
  localparam int IN_DATA_W  = 3 * COORD_W;
  localparam int OUT_DATA_W = ((3 * OUT_W + 7) / 8) * 8;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COORD_W;

  localparam logic [CFG_IDX_W-1:0] REG_CAM_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_YAW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH = 3'd4;

  localparam logic signed [COORD_W-1:0] CAM_X_RST = 24'sd245760;
  localparam logic signed [COORD_W-1:0] CAM_Y_RST = 24'sd271360;
  localparam logic signed [COORD_W-1:0] CAM_Z_RST = 24'sd0;

  // One in the trig format (Q2.16).
  localparam logic signed [TRIG_W-1:0] TRIG_ONE = TRIG_W'(1 << TRIG_FRAC);

  // Cached sine and cosine values of both angles.
  typedef struct packed {
    logic signed [TRIG_W-1:0] yaw_cos;
    logic signed [TRIG_W-1:0] yaw_sin;
    logic signed [TRIG_W-1:0] pitch_cos;
    logic signed [TRIG_W-1:0] pitch_sin;
  } trig_t;

  // Angle register writes toward the trig sequencer.
  typedef struct packed {
    logic             yaw_we;
    logic             pitch_we;
    logic [ANG_W-1:0] angle;
  } ang_wr_t;

  // One item entering a plane rotation: (a, b) rotated by (c, s).
  typedef struct packed {
    logic signed [ROT_W-1:0]  a;
    logic signed [ROT_W-1:0]  b;
    logic signed [TRIG_W-1:0] c;
    logic signed [TRIG_W-1:0] s;
    logic [SIDE_W-1:0]        side;
  } rot_in_t;

  // One item leaving a plane rotation.
  typedef struct packed {
    logic signed [ROT_W-1:0] x;
    logic signed [ROT_W-1:0] y;
    logic [SIDE_W-1:0]       side;
  } rot_out_t;

endpackage

`default_nettype wire

/* src/cvr_trig.sv */
// ---------------------------------------------------------------------------
// cvr_trig: sine and cosine sequencer for the yaw and pitch angles
// Evaluates a quarter-wave Taylor series in Q30 with one multiplication
// per state and a reciprocal multiplication, split in two halves, for the
// series coefficients, then rounds the result into Q2.16 and caches it.
// ---------------------------------------------------------------------------
`default_nettype none

module cvr_trig (
  input  logic            clk,
  input  logic            rst_n,
  input  cvr_pkg::ang_wr_t wr_i,
  output cvr_pkg::trig_t  trig_o,
  output logic            busy_o
);
  import cvr_pkg::*;

  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam int          RND_SHIFT   = 30 - TRIG_FRAC;
  localparam logic [14:0] QUARTER     = 15'd16384;
  localparam logic [2:0]  K_LAST      = 3'd5;
  localparam int          RECIP_W     = 38;
  localparam int          RECIP_SPLIT = 19;
  localparam int          RECIP_SHIFT = 40;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b00000001,
    ST_SETUP = 8'b00000010,
    ST_SQ    = 8'b00000100,
    ST_TM    = 8'b00001000,
    ST_DLO   = 8'b00010000,
    ST_DHI   = 8'b00100000,
    ST_ACC   = 8'b01000000,
    ST_FIN   = 8'b10000000
  } trig_state_t;

  // Reciprocal ceil(2^40 / ((2k)(2k+1))) of the k-th series divisor. The
  // product error stays below one quotient step for any 33-bit dividend.
  function automatic logic [RECIP_W-1:0] series_recip(input logic [2:0] k);
    logic [RECIP_W-1:0] m;
    case (k)
      3'd1:    m = 38'd183251937963;
      3'd2:    m = 38'd54975581389;
      3'd3:    m = 38'd26178848281;
      3'd4:    m = 38'd15270994831;
      default: m = 38'd9995560253;
    endcase
    return m;
  endfunction

  trig_state_t        state_r, state_nxt;
  logic [ANG_W-1:0]   yaw_ang_r, pitch_ang_r;
  logic               yaw_pend_r, yaw_pend_nxt;
  logic               pitch_pend_r, pitch_pend_nxt;
  logic               tgt_pitch_r, tgt_pitch_nxt;
  logic               cos_ph_r, cos_ph_nxt;
  logic               neg_r, neg_nxt;
  logic [30:0]        x_r, x_nxt;
  logic [31:0]        x2_r, x2_nxt;
  logic [30:0]        term_r, term_nxt;
  logic signed [33:0] sum_r, sum_nxt;
  logic [2:0]         k_r, k_nxt;
  logic [32:0]        dq_r, dq_nxt;
  logic [51:0]        pl_r, pl_nxt;
  trig_t              trig_r, trig_nxt;

  // Combinational helpers.
  logic [ANG_W-1:0]         ang, ang_ph;
  logic [13:0]              ang_low;
  logic [14:0]              u;
  logic [46:0]              u_prod;
  logic [61:0]              sq_prod;
  logic [62:0]              tm_prod;
  logic [RECIP_W-1:0]       recip;
  logic [51:0]              lo_prod, hi_prod;
  logic [52:0]              quot_sum;
  logic signed [33:0]       sum_pos, sum_rnd;
  logic [33-RND_SHIFT:0]    mag;
  logic signed [TRIG_W-1:0] mag_sat, trig_val;

  // Quadrant folding and the first products.
  assign ang     = tgt_pitch_r ? pitch_ang_r : yaw_ang_r;
  assign ang_ph  = ang + (cos_ph_r ? ANG_W'(QUARTER) : '0);
  assign ang_low = ang_ph[13:0];
  assign u       = ang_ph[14] ? (QUARTER - {1'b0, ang_low}) : {1'b0, ang_low};
  assign u_prod  = 47'(u) * 47'(PI_Q30);
  assign sq_prod = 62'(x_r) * 62'(x_r);
  assign tm_prod = 63'(term_r) * 63'(x2_r);

  // Division by the series divisor: the dividend times the reciprocal, low
  // half of the reciprocal in ST_DLO and high half in ST_DHI.
  assign recip    = series_recip(k_r);
  assign lo_prod  = 52'(dq_r) * 52'(recip[RECIP_SPLIT-1:0]);
  assign hi_prod  = 52'(dq_r) * 52'(recip[RECIP_W-1:RECIP_SPLIT]);
  assign quot_sum = 53'(hi_prod) + 53'(pl_r[51:RECIP_SPLIT]);

  // Clamp at zero, round to the trig format, clamp at one.
  assign sum_pos  = sum_r[33] ? '0 : sum_r;
  assign sum_rnd  = sum_pos + (34'sd1 <<< (RND_SHIFT - 1));
  assign mag      = sum_rnd[33:RND_SHIFT];
  assign mag_sat  = (mag > (34-RND_SHIFT)'(TRIG_ONE)) ? TRIG_ONE : TRIG_W'(mag);
  assign trig_val = neg_r ? -mag_sat : mag_sat;

  assign busy_o = (state_r != ST_IDLE) || yaw_pend_r || pitch_pend_r;
  assign trig_o = trig_r;

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    yaw_pend_nxt   = yaw_pend_r;
    pitch_pend_nxt = pitch_pend_r;
    tgt_pitch_nxt  = tgt_pitch_r;
    cos_ph_nxt     = cos_ph_r;
    neg_nxt        = neg_r;
    x_nxt          = x_r;
    x2_nxt         = x2_r;
    term_nxt       = term_r;
    sum_nxt        = sum_r;
    k_nxt          = k_r;
    dq_nxt         = dq_r;
    pl_nxt         = pl_r;
    trig_nxt       = trig_r;
    case (state_r)
      ST_IDLE: begin
        if (yaw_pend_r) begin
          yaw_pend_nxt  = 1'b0;
          tgt_pitch_nxt = 1'b0;
          cos_ph_nxt    = 1'b0;
          state_nxt     = ST_SETUP;
        end else if (pitch_pend_r) begin
          pitch_pend_nxt = 1'b0;
          tgt_pitch_nxt  = 1'b1;
          cos_ph_nxt     = 1'b0;
          state_nxt      = ST_SETUP;
        end
      end
      ST_SETUP: begin
        x_nxt     = u_prod[45:15];
        neg_nxt   = ang_ph[15];
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        x2_nxt    = sq_prod[61:30];
        term_nxt  = x_r;
        sum_nxt   = 34'(x_r);
        k_nxt     = 3'd1;
        state_nxt = ST_TM;
      end
      ST_TM: begin
        dq_nxt    = tm_prod[62:30];
        state_nxt = ST_DLO;
      end
      ST_DLO: begin
        pl_nxt    = lo_prod;
        state_nxt = ST_DHI;
      end
      ST_DHI: begin
        dq_nxt    = 33'(quot_sum[52:RECIP_SHIFT-RECIP_SPLIT]);
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        term_nxt = dq_r[30:0];
        sum_nxt  = k_r[0] ? (sum_r - $signed(34'(dq_r))) : (sum_r + $signed(34'(dq_r)));
        k_nxt    = k_r + 3'd1;
        state_nxt = (k_r == K_LAST) ? ST_FIN : ST_TM;
      end
      ST_FIN: begin
        case ({tgt_pitch_r, cos_ph_r})
          2'b00:   trig_nxt.yaw_sin   = trig_val;
          2'b01:   trig_nxt.yaw_cos   = trig_val;
          2'b10:   trig_nxt.pitch_sin = trig_val;
          default: trig_nxt.pitch_cos = trig_val;
        endcase
        if (!cos_ph_r) begin
          cos_ph_nxt = 1'b1;
          state_nxt  = ST_SETUP;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    // A new write always schedules a fresh evaluation.
    if (wr_i.yaw_we) begin
      yaw_pend_nxt = 1'b1;
    end
    if (wr_i.pitch_we) begin
      pitch_pend_nxt = 1'b1;
    end
  end

  // Control and cached results.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= ST_IDLE;
      yaw_ang_r         <= '0;
      pitch_ang_r       <= '0;
      yaw_pend_r        <= 1'b0;
      pitch_pend_r      <= 1'b0;
      tgt_pitch_r       <= 1'b0;
      cos_ph_r          <= 1'b0;
      k_r               <= 3'd1;
      trig_r.yaw_cos    <= TRIG_ONE;
      trig_r.yaw_sin    <= '0;
      trig_r.pitch_cos  <= TRIG_ONE;
      trig_r.pitch_sin  <= '0;
    end else begin
      state_r      <= state_nxt;
      yaw_pend_r   <= yaw_pend_nxt;
      pitch_pend_r <= pitch_pend_nxt;
      tgt_pitch_r  <= tgt_pitch_nxt;
      cos_ph_r     <= cos_ph_nxt;
      k_r          <= k_nxt;
      trig_r       <= trig_nxt;
      if (wr_i.yaw_we) begin
        yaw_ang_r <= wr_i.angle;
      end
      if (wr_i.pitch_we) begin
        pitch_ang_r <= wr_i.angle;
      end
    end
  end

  // Series datapath.
  always_ff @(posedge clk) begin
    neg_r  <= neg_nxt;
    x_r    <= x_nxt;
    x2_r   <= x2_nxt;
    term_r <= term_nxt;
    sum_r  <= sum_nxt;
    dq_r   <= dq_nxt;
    pl_r   <= pl_nxt;
  end

endmodule

`default_nettype wire

/* src/cvr_rotate.sv */
// ---------------------------------------------------------------------------
// cvr_rotate: two-stage plane rotation with rounding
// Stage one forms the four products, stage two adds them, rounds to
// nearest and saturates. Each stage holds its item while the next is full.
// ---------------------------------------------------------------------------
`default_nettype none

module cvr_rotate (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cvr_pkg::rot_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cvr_pkg::rot_out_t out_data
);
  import cvr_pkg::*;

  localparam int SH_W = ACC_W - TRIG_FRAC;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (TRIG_FRAC - 1);

  // Round off the fraction bits and saturate to the output width.
  function automatic logic signed [ROT_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] r;
    logic [SH_W-1:0]         sh;
    logic                    fits;
    r    = acc + HALF;
    sh   = r[ACC_W-1:TRIG_FRAC];
    fits = (&sh[SH_W-1:ROT_W-1]) || !(|sh[SH_W-1:ROT_W-1]);
    if (fits) begin
      return sh[ROT_W-1:0];
    end else if (sh[SH_W-1]) begin
      return {1'b1, {(ROT_W-1){1'b0}}};
    end else begin
      return {1'b0, {(ROT_W-1){1'b1}}};
    end
  endfunction

  logic                     va_r, vb_r, rdy_b;
  logic signed [PROD_W-1:0] p_ac_r, p_bs_r, p_as_r, p_bc_r;
  logic signed [PROD_W-1:0] p_ac_nxt, p_bs_nxt, p_as_nxt, p_bc_nxt;
  logic [SIDE_W-1:0]        side_a_r;
  rot_out_t                 out_r, out_nxt;

  // Stage readiness: a stage takes an item when empty or draining.
  assign rdy_b     = !vb_r || out_ready;
  assign in_ready  = !va_r || rdy_b;
  assign out_valid = vb_r;
  assign out_data  = out_r;

  // Products.
  assign p_ac_nxt = in_data.a * in_data.c;
  assign p_bs_nxt = in_data.b * in_data.s;
  assign p_as_nxt = in_data.a * in_data.s;
  assign p_bc_nxt = in_data.b * in_data.c;

  // Sums, rounding and saturation.
  always_comb begin
    out_nxt.x    = round_sat(ACC_W'(p_ac_r) - ACC_W'(p_bs_r));
    out_nxt.y    = round_sat(ACC_W'(p_as_r) + ACC_W'(p_bc_r));
    out_nxt.side = side_a_r;
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (in_ready) begin
        va_r <= in_valid;
      end
      if (rdy_b) begin
        vb_r <= va_r;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      p_ac_r   <= p_ac_nxt;
      p_bs_r   <= p_bs_nxt;
      p_as_r   <= p_as_nxt;
      p_bc_r   <= p_bc_nxt;
      side_a_r <= in_data.side;
    end
    if (rdy_b && va_r) begin
      out_r <= out_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/camera_view_rotate_unit.sv */
// ---------------------------------------------------------------------------
// camera_view_rotate_unit: camera-relative yaw/pitch point transform
// Subtracts the camera position from a point, rotates it by yaw in the x-z
// plane and then by pitch in the y-z plane.
// ---------------------------------------------------------------------------
// Usage:
//   The in_ channel carries one point per item; in_tuser set asks for both
//   angles negated (same yaw-then-pitch order). The out_ channel returns one
//   camera-relative point per item, in the same order.
//   The path from the accepting edge to out_tvalid holds five register
//   stages, one for the subtraction, then two (products, rounded sums) per
//   rotation.
//   Throughput is one item per clock while the trig sequencer is idle; every
//   stage has its own valid bit, so when the receiver holds out_tready low
//   the pipeline fills up its empty stages first and only then drops in_tready.
//   Writing yaw_angle or pitch_angle starts the sine/cosine sequencer, which
//   evaluates sine and then cosine for each angle written (one multiplier step
//   per state and a reciprocal multiplication in two halves for each of the
//   five series terms after the first); in_tready stays low until it is done.
//   A synchronous reset (rst_n low) empties the pipeline and loads the
//   default camera position with both angles at zero.
// ---------------------------------------------------------------------------
`default_nettype none

module camera_view_rotate_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input items.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [cvr_pkg::IN_DATA_W-1:0]     in_tdata,  // point_x, point_y, point_z
  input  logic                              in_tuser,  // req_type
  // Result items.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [cvr_pkg::OUT_DATA_W-1:0]    out_tdata, // view_x, view_y, view_z, zero pad
  // Configuration writes.
  input  logic                              cfg_wen,
  input  logic [cvr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cvr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import cvr_pkg::*;

  // Widen a coordinate to the rotation width.
  function automatic logic signed [ROT_W-1:0] widen(input logic [COORD_W-1:0] v);
    return {{(ROT_W-COORD_W){v[COORD_W-1]}}, v};
  endfunction

  logic signed [COORD_W-1:0] cam_x_r, cam_y_r, cam_z_r;
  ang_wr_t                   ang_wr;
  trig_t                     trig;
  logic                      trig_busy;

  logic                      v1_r, ready1, in_acc;
  logic                      back_r;
  logic signed [ROT_W-1:0]   dx_r, dy_r, dz_r;
  logic signed [TRIG_W-1:0]  sy_r;

  rot_in_t                   yaw_in, pitch_in;
  rot_out_t                  yaw_out, pitch_out;
  logic                      yaw_in_ready, yaw_out_valid, pitch_in_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r <= CAM_X_RST;
      cam_y_r <= CAM_Y_RST;
      cam_z_r <= CAM_Z_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_CAM_X: cam_x_r <= cfg_wdata;
        REG_CAM_Y: cam_y_r <= cfg_wdata;
        REG_CAM_Z: cam_z_r <= cfg_wdata;
        default:   ;
      endcase
    end
  end

  // Angle writes go to the trig sequencer.
  assign ang_wr.yaw_we   = cfg_wen && (cfg_index == REG_YAW);
  assign ang_wr.pitch_we = cfg_wen && (cfg_index == REG_PITCH);
  assign ang_wr.angle    = cfg_wdata[ANG_W-1:0];

  cvr_trig u_trig (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_i   (ang_wr),
    .trig_o (trig),
    .busy_o (trig_busy)
  );

  // Input stage: camera offset and sine sign selection.
  assign ready1    = !v1_r || yaw_in_ready;
  assign in_tready = ready1 && !trig_busy;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (ready1) begin
      v1_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      back_r <= in_tuser;
      dx_r   <= widen(in_tdata[COORD_W-1:0]) - widen(cam_x_r);
      dy_r   <= widen(in_tdata[2*COORD_W-1:COORD_W]) - widen(cam_y_r);
      dz_r   <= widen(in_tdata[3*COORD_W-1:2*COORD_W]) - widen(cam_z_r);
      sy_r   <= in_tuser ? -trig.yaw_sin : trig.yaw_sin;
    end
  end

  // Yaw rotation in the x-z plane; dy and the request kind ride along.
  assign yaw_in.a    = dx_r;
  assign yaw_in.b    = dz_r;
  assign yaw_in.c    = trig.yaw_cos;
  assign yaw_in.s    = sy_r;
  assign yaw_in.side = {back_r, dy_r};

  cvr_rotate u_yaw (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v1_r),
    .in_ready  (yaw_in_ready),
    .in_data   (yaw_in),
    .out_valid (yaw_out_valid),
    .out_ready (pitch_in_ready),
    .out_data  (yaw_out)
  );

  // Pitch rotation in the y-z plane; view_x rides along.
  assign pitch_in.a    = yaw_out.side[ROT_W-1:0];
  assign pitch_in.b    = yaw_out.y;
  assign pitch_in.c    = trig.pitch_cos;
  assign pitch_in.s    = yaw_out.side[SIDE_W-1] ? -trig.pitch_sin : trig.pitch_sin;
  assign pitch_in.side = {1'b0, yaw_out.x};

  cvr_rotate u_pitch (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (yaw_out_valid),
    .in_ready  (pitch_in_ready),
    .in_data   (pitch_in),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (pitch_out)
  );

  // Result packing.
  assign out_tdata = {{(OUT_DATA_W-3*OUT_W){1'b0}}, pitch_out.y, pitch_out.x,
                      pitch_out.side[ROT_W-1:0]};

  // No item may enter while sine and cosine are being recomputed.
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    trig_busy |-> !in_tready)
    else $error("item accepted while trig values are being recomputed");

  // An angle write must make the sequencer busy on the next cycle.
  a_angle_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wen && (cfg_index == REG_YAW || cfg_index == REG_PITCH) |=> trig_busy)
    else $error("angle write did not start the trig sequencer");

  // Cached sine and cosine values never exceed one in magnitude.
  a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
    trig.yaw_cos <= TRIG_ONE && trig.yaw_cos >= -TRIG_ONE &&
    trig.yaw_sin <= TRIG_ONE && trig.yaw_sin >= -TRIG_ONE &&
    trig.pitch_cos <= TRIG_ONE && trig.pitch_cos >= -TRIG_ONE &&
    trig.pitch_sin <= TRIG_ONE && trig.pitch_sin >= -TRIG_ONE)
    else $error("trig value out of range");

  // An accepted item always lands in the input stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v1_r)
    else $error("accepted item lost at the input stage");

endmodule

`default_nettype wire
